### rtl/cctd_pkg.sv
// Shared types, constants and helper functions of the cyclic code error-trapping decoder.
package cctd_pkg;

	localparam int MAX_LEN = 32;
	localparam int WORD_W = 32;
	localparam int SYN_W = 31;
	localparam int LEN_W = 6;
	localparam int DEG_W = 5;
	localparam int T_W = 4;
	localparam int LEN_CAP = (MAX_LEN < WORD_W) ? MAX_LEN : WORD_W;
	localparam int QUEUE_DEPTH = 2;

	// Configuration register indexes
	localparam int IDX_W = 2;
	localparam logic [IDX_W-1:0] REG_GEN = 2'd0;
	localparam logic [IDX_W-1:0] REG_LEN = 2'd1;
	localparam logic [IDX_W-1:0] REG_T = 2'd2;

	localparam logic [WORD_W-1:0] GEN_RST = 32'd2585;
	localparam logic [LEN_W-1:0] LEN_RST = 6'd21;
	localparam logic [T_W-1:0] T_RST = 4'd2;

	// Decoded configuration shared by front and back
	typedef struct packed {
		logic [WORD_W-1:0] g;
		logic [DEG_W-1:0]  dg;
		logic [LEN_W-1:0]  n;
		logic [T_W-1:0]    t;
		logic [WORD_W-1:0] nmask;
	} cctd_cfg_t;

	// One classified word on its way from front to back
	typedef struct packed {
		logic [WORD_W-1:0] r;
		logic [SYN_W-1:0]  s0;
		logic [SYN_W-1:0]  s;
		logic [LEN_W-1:0]  shifts;
		logic              trapped;
		logic              zero_g;
	} cctd_entry_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_SYN,
		F_TRAP,
		F_PUSH
	} cctd_front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_FOLD,
		B_ROT,
		B_DIV_GO,
		B_DIV
	} cctd_back_state_t;

	// Degree of a polynomial: index of its highest set bit
	function automatic logic [DEG_W-1:0] top_bit(input logic [WORD_W-1:0] v);
		logic [DEG_W-1:0] d;
		d = '0;
		for (int k = 0; k < WORD_W; k++) begin
			if (v[k]) begin
				d = DEG_W'(k);
			end
		end
		return d;
	endfunction

	// Mask of the low n bits
	function automatic logic [WORD_W-1:0] len_mask(input logic [LEN_W-1:0] n);
		logic [WORD_W-1:0] m;
		for (int k = 0; k < WORD_W; k++) begin
			m[k] = (LEN_W'(k) < n);
		end
		return m;
	endfunction

	// Rotate left by one within n bits (n at least one)
	function automatic logic [WORD_W-1:0] rotl_n(input logic [WORD_W-1:0] e,
	                                             input logic [LEN_W-1:0] n);
		logic [DEG_W-1:0] idx;
		idx = DEG_W'(n - LEN_W'(1));
		return ({e[WORD_W-2:0], 1'b0} & len_mask(n)) | {{(WORD_W-1){1'b0}}, e[idx]};
	endfunction

	// Rotate right by one within n bits (n at least one)
	function automatic logic [WORD_W-1:0] rotr_n(input logic [WORD_W-1:0] e,
	                                             input logic [LEN_W-1:0] n);
		logic [DEG_W-1:0] idx;
		logic [WORD_W-1:0] wrap;
		idx = DEG_W'(n - LEN_W'(1));
		wrap = e[0] ? (WORD_W'(1) << idx) : '0;
		return {1'b0, e[WORD_W-1:1]} | wrap;
	endfunction

endpackage

### rtl/cctd_div.sv
// Bit-serial polynomial long divider over GF(2), one dividend bit per cycle.
module cctd_div import cctd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [WORD_W-1:0] dividend,
	input  logic [LEN_W-1:0]  nbits,
	input  logic [WORD_W-1:0] g,
	input  logic [DEG_W-1:0]  dg,
	output logic              done,
	output logic [WORD_W-1:0] quo,
	output logic [SYN_W-1:0]  rem
);

	logic              busy_q;
	logic              done_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [WORD_W-1:0] dvd_q;
	logic [SYN_W-1:0]  rem_q;
	logic [WORD_W-1:0] quo_q;
	logic              bit_in;
	logic [WORD_W-1:0] shifted;
	logic              top;
	logic [WORD_W-1:0] rem_nx;

	// Shift in the next dividend bit and reduce by g
	always_comb begin
		bit_in = dvd_q[DEG_W'(cnt_q - LEN_W'(1))];
		shifted = {rem_q, bit_in};
		top = shifted[dg];
		rem_nx = top ? (shifted ^ g) : shifted;
	end

	// Control: count down the dividend bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= nbits;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - LEN_W'(1);
				end
			end
		end
	end

	// Datapath: remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= rem_nx[SYN_W-1:0];
			quo_q <= {quo_q[WORD_W-2:0], top};
		end
	end

	assign done = done_q;
	assign quo = quo_q;
	assign rem = rem_q;

endmodule

### rtl/cctd_front.sv
// Front end: accepts a word, computes its syndrome and searches for the trapping shift.
module cctd_front import cctd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cctd_cfg_t         cfg,
	input  logic              start,
	output logic              busy,
	input  logic [WORD_W-1:0] received_word,
	input  logic              full,
	output logic              push,
	output cctd_entry_t       entry
);

	cctd_front_state_t state_q, state_nx;

	logic              accept;
	logic              gen_zero;
	logic              div_go;
	logic              div_done;
	logic [WORD_W-1:0] div_quo;
	logic [SYN_W-1:0]  div_rem;
	logic [WORD_W-1:0] r_q;
	logic [SYN_W-1:0]  s0_q;
	logic [SYN_W-1:0]  s_q;
	logic [LEN_W-1:0]  shifts_q;
	logic              trapped_q;
	logic              zero_g_q;
	logic              hit;
	logic              last;
	logic [WORD_W-1:0] s_tmp;
	logic [SYN_W-1:0]  s_shift;

	assign gen_zero = (cfg.g == '0);
	assign accept = start && (state_q == F_IDLE);
	assign div_go = accept && !gen_zero;

	cctd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (received_word & cfg.nmask),
		.nbits    (cfg.n),
		.g        (cfg.g),
		.dg       (cfg.dg),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// Trap test and one cyclic syndrome shift
	always_comb begin
		hit = (5'($countones(s_q)) <= {1'b0, cfg.t});
		last = ((shifts_q + LEN_W'(1)) == cfg.n);
		s_tmp = {s_q, 1'b0};
		if (s_tmp[cfg.dg]) begin
			s_tmp = s_tmp ^ cfg.g;
		end
		s_shift = s_tmp[SYN_W-1:0];
	end

	// Next state and handshake
	always_comb begin
		state_nx = state_q;
		push = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				if (start) begin
					state_nx = gen_zero ? F_PUSH : F_SYN;
				end
			end
			F_SYN: begin
				if (div_done) begin
					state_nx = (cfg.n == '0) ? F_PUSH : F_TRAP;
				end
			end
			F_TRAP: begin
				if (hit || last) begin
					state_nx = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!full) begin
					push = 1'b1;
					state_nx = F_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Hold the word under classification
	always_ff @(posedge clk) begin
		if (accept) begin
			r_q <= received_word & cfg.nmask;
			zero_g_q <= gen_zero;
			trapped_q <= 1'b0;
			shifts_q <= '0;
			s0_q <= '0;
			s_q <= '0;
		end else if (state_q == F_SYN && div_done) begin
			s0_q <= div_rem;
			s_q <= div_rem;
		end else if (state_q == F_TRAP) begin
			if (hit) begin
				trapped_q <= 1'b1;
			end else if (last) begin
				shifts_q <= cfg.n;
			end else begin
				s_q <= s_shift;
				shifts_q <= shifts_q + LEN_W'(1);
			end
		end
	end

	assign busy = (state_q != F_IDLE);

	always_comb begin
		entry.r = r_q;
		entry.s0 = s0_q;
		entry.s = s_q;
		entry.shifts = shifts_q;
		entry.trapped = trapped_q;
		entry.zero_g = zero_g_q;
	end

endmodule

### rtl/cctd_fifo.sv
// Short queue of classified words between the front and the back.
module cctd_fifo import cctd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  cctd_entry_t din,
	output logic        full,
	input  logic        pop,
	output cctd_entry_t dout,
	output logic        empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cctd_entry_t      mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [CNT_W-1:0] cnt_q;

	// Advance a pointer with wrap at the depth
	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= ptr_inc(wp_q);
			end
			if (pop) begin
				rp_q <= ptr_inc(rp_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Store the entry on a transfer in
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

	assign dout = mem_q[rp_q];
	assign full = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);

endmodule

### rtl/cctd_back.sv
// Back end: rebuilds the error pattern, corrects the word and divides out the message.
module cctd_back import cctd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cctd_cfg_t         cfg,
	input  logic              empty,
	output logic              pop,
	input  cctd_entry_t       entry,
	output logic              done,
	output logic [WORD_W-1:0] message_word,
	output logic [WORD_W-1:0] error_pattern,
	output logic [SYN_W-1:0]  syndrome_out,
	output logic [LEN_W-1:0]  shift_count,
	output logic              uncorrectable
);

	cctd_back_state_t state_q, state_nx;

	cctd_entry_t       ent_q;
	logic [WORD_W-1:0] err_q;
	logic [LEN_W-1:0]  cnt_q;
	logic              div_go;
	logic              div_done;
	logic [WORD_W-1:0] div_quo;
	logic [SYN_W-1:0]  div_rem;
	logic              done_q;
	logic              emit;
	logic              emit_zero;
	logic [WORD_W-1:0] msg_q;
	logic [WORD_W-1:0] errp_q;
	logic [SYN_W-1:0]  syn_q;
	logic [LEN_W-1:0]  shc_q;
	logic              unc_q;

	cctd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (ent_q.r ^ err_q),
		.nbits    (cfg.n),
		.g        (cfg.g),
		.dg       (cfg.dg),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// Next state and strobes
	always_comb begin
		state_nx = state_q;
		pop = 1'b0;
		div_go = 1'b0;
		emit = 1'b0;
		emit_zero = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					if (entry.zero_g) begin
						emit_zero = 1'b1;
					end else if (entry.trapped) begin
						state_nx = B_FOLD;
					end else begin
						state_nx = B_DIV_GO;
					end
				end
			end
			B_FOLD: begin
				if (cnt_q == '0) begin
					state_nx = B_ROT;
				end
			end
			B_ROT: begin
				if (cnt_q == '0) begin
					state_nx = B_DIV_GO;
				end
			end
			B_DIV_GO: begin
				div_go = 1'b1;
				state_nx = B_DIV;
			end
			B_DIV: begin
				if (div_done) begin
					emit = 1'b1;
					state_nx = B_IDLE;
				end
			end
			default: begin
				state_nx = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q <= emit || emit_zero;
		end
	end

	// Fold the trapped syndrome modulo x^n+1, then rotate it back by the shift count
	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= entry;
			err_q <= '0;
			cnt_q <= {1'b0, cfg.dg};
		end else if (state_q == B_FOLD) begin
			if (cnt_q == '0) begin
				cnt_q <= ent_q.shifts;
			end else begin
				err_q <= rotl_n(err_q, cfg.n)
				       ^ {{(WORD_W-1){1'b0}}, ent_q.s[DEG_W'(cnt_q - LEN_W'(1))]};
				cnt_q <= cnt_q - LEN_W'(1);
			end
		end else if (state_q == B_ROT && cnt_q != '0) begin
			err_q <= rotr_n(err_q, cfg.n);
			cnt_q <= cnt_q - LEN_W'(1);
		end
	end

	// Register the result for its one-cycle transfer out
	always_ff @(posedge clk) begin
		if (emit_zero) begin
			msg_q <= '0;
			errp_q <= '0;
			syn_q <= '0;
			shc_q <= '0;
			unc_q <= 1'b1;
		end else if (emit) begin
			msg_q <= div_quo;
			errp_q <= err_q;
			syn_q <= ent_q.s0;
			shc_q <= ent_q.shifts;
			unc_q <= !ent_q.trapped;
		end
	end

	assign done = done_q;
	assign message_word = msg_q;
	assign error_pattern = errp_q;
	assign syndrome_out = syn_q;
	assign shift_count = shc_q;
	assign uncorrectable = unc_q;

endmodule

### rtl/cyclic_code_error_trap_decoder.sv
// Top level of the cyclic code error-trapping decoder: configuration registers, front, queue, back.
// Front: accept, syndrome division, trial syndrome shifts until a trap or the last shift, then push;
//   busy stays high until the push, longer while the queue is full.
// Back: pop, fold and rotate (trapped words only), a division launch, then the division of the
//   corrected word.
// Throughput is one word per the slower pass; the queue lets the front take a new word while the
//   back still works on earlier ones.
// Results are strobed for one cycle on done and cannot be held off by the receiver.
// Reset (arst_n low) clears all control state and loads g=2585, n=21, t=2.
module cyclic_code_error_trap_decoder import cctd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_index,
	input  logic [WORD_W-1:0] wr_data,
	input  logic              start,
	output logic              busy,
	input  logic [WORD_W-1:0] received_word,
	output logic              done,
	output logic [WORD_W-1:0] message_word,
	output logic [WORD_W-1:0] error_pattern,
	output logic [SYN_W-1:0]  syndrome_out,
	output logic [LEN_W-1:0]  shift_count,
	output logic              uncorrectable
);

	logic [WORD_W-1:0] gen_q;
	logic [LEN_W-1:0]  len_q;
	logic [T_W-1:0]    t_q;
	logic [LEN_W-1:0]  n_eff;
	cctd_cfg_t         cfg;
	logic              q_push;
	logic              q_full;
	logic              q_pop;
	logic              q_empty;
	cctd_entry_t       q_din;
	cctd_entry_t       q_dout;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= GEN_RST;
			len_q <= LEN_RST;
			t_q <= T_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_GEN: gen_q <= wr_data;
				REG_LEN: len_q <= wr_data[LEN_W-1:0];
				REG_T:   t_q <= wr_data[T_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Saturate the length and decode the generator
	always_comb begin
		n_eff = (len_q > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : len_q;
		cfg.g = gen_q;
		cfg.dg = top_bit(gen_q);
		cfg.n = n_eff;
		cfg.t = t_q;
		cfg.nmask = len_mask(n_eff);
	end

	cctd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.start         (start),
		.busy          (busy),
		.received_word (received_word),
		.full          (q_full),
		.push          (q_push),
		.entry         (q_din)
	);

	cctd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	cctd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.empty         (q_empty),
		.pop           (q_pop),
		.entry         (q_dout),
		.done          (done),
		.message_word  (message_word),
		.error_pattern (error_pattern),
		.syndrome_out  (syndrome_out),
		.shift_count   (shift_count),
		.uncorrectable (uncorrectable)
	);

	// An accepted word keeps the front busy in the following cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("front not busy after accepting a word");

	// The queue never takes a transfer while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("queue overflow");

	// The queue never gives a transfer while empty
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_empty))
		else $error("queue underflow");

	// An uncorrectable result carries no error pattern
	a_unc_zero_err: assert property (@(posedge clk) disable iff (!arst_n)
		(done && uncorrectable) |-> (error_pattern == '0))
		else $error("nonzero error pattern on uncorrectable word");

endmodule
